// ===== sv/mpeg_audio_header_decoder_unit_defines.svh =====
// Assertion macros shared by the MPEG audio header decoder modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MPEG_AUDIO_HEADER_DECODER_UNIT_DEFINES_SVH
`define MPEG_AUDIO_HEADER_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MAHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MAHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mahd_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and tables for the MPEG audio header decoder.
// Used by every module of the block; depends on nothing.
package mahd_pkg;

  localparam logic [10:0] SYNC_PATTERN = 11'h7FF;

  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSV    = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  localparam logic [1:0] LAYER_RSV = 2'd0;
  localparam logic [1:0] LAYER_3   = 2'd1;
  localparam logic [1:0] LAYER_2   = 2'd2;
  localparam logic [1:0] LAYER_1   = 2'd3;

  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;
  localparam logic [1:0] SIDX_RSV  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SYNC     = 3'd1,
    ST_RSV_VERSION = 3'd2,
    ST_RSV_LAYER   = 3'd3,
    ST_BAD_BITRATE = 3'd4,
    ST_RSV_RATE    = 3'd5,
    ST_FREE_FORMAT = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BASE_44K1 = 2'd0,
    BASE_48K  = 2'd1,
    BASE_32K  = 2'd2
  } base_t;

  // Reciprocals of the base rates, scaled so that slots * 1000 / base
  // equals (slots * recip) >> RECIP_SHIFT exactly for 17-bit slot counts.
  localparam int unsigned RECIP_SHIFT = 26;
  localparam logic [21:0] RECIP_44K1 = 22'(((64'd10 << RECIP_SHIFT) + 64'd440) / 64'd441);
  localparam logic [21:0] RECIP_48K  = 22'(((64'd1 << RECIP_SHIFT) + 64'd47) / 64'd48);
  localparam logic [21:0] RECIP_32K  = 22'((64'd1 << RECIP_SHIFT) / 64'd32);

  localparam logic [8:0] BR_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] BR_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] BR_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BR_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] BR_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                input logic [1:0] lay,
                                                input logic [3:0] idx);
    logic [8:0] br;
    if (ver == VER_MPEG1) begin
      if (lay == LAYER_1) br = BR_V1_L1[idx];
      else if (lay == LAYER_2) br = BR_V1_L2[idx];
      else br = BR_V1_L3[idx];
    end else begin
      if (lay == LAYER_1) br = BR_V2_L1[idx];
      else br = BR_V2_L23[idx];
    end
    return br;
  endfunction

  // Classified header as it waits between the front and back parts.
  typedef struct packed {
    status_t     status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic        crc_present;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_mode;
    logic [16:0] slots;
    base_t       base_sel;
    logic        layer_one;
  } item_t;

  // Result word, laid out so that the last field sits in the lowest bits.
  typedef struct packed {
    logic [11:0] frame_length;
    logic [1:0]  channel_mode;
    logic        padding_bit;
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic        crc_present;
    logic [1:0]  layer_code;
    logic [1:0]  version_code;
    status_t     status;
  } result_t;

endpackage

// ===== sv/mahd_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts header words, checks sync and decodes fields and tables.
// Depends on mahd_pkg.
module mahd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // header_word[31:0]
  output logic             q_valid,
  input  logic             q_ready,
  output mahd_pkg::item_t  q_item
);

  logic            valid_r, valid_nxt;
  mahd_pkg::item_t item_r, item_nxt;

  logic [1:0]  ver, lay, sidx, shift;
  logic [3:0]  bidx;
  logic [8:0]  br;
  logic [15:0] base_hz, sr_hz;
  logic [16:0] kbr;
  logic [18:0] slots_w;
  mahd_pkg::status_t status;
  logic        accept;

  assign ver  = in_tdata[20:19];
  assign lay  = in_tdata[18:17];
  assign bidx = in_tdata[15:12];
  assign sidx = in_tdata[11:10];

  assign in_tready = !valid_r || q_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (in_tdata[31:21] != mahd_pkg::SYNC_PATTERN) status = mahd_pkg::ST_NO_SYNC;
    else if (ver == mahd_pkg::VER_RSV) status = mahd_pkg::ST_RSV_VERSION;
    else if (lay == mahd_pkg::LAYER_RSV) status = mahd_pkg::ST_RSV_LAYER;
    else if (bidx == mahd_pkg::BIDX_BAD) status = mahd_pkg::ST_BAD_BITRATE;
    else if (sidx == mahd_pkg::SIDX_RSV) status = mahd_pkg::ST_RSV_RATE;
    else if (bidx == mahd_pkg::BIDX_FREE) status = mahd_pkg::ST_FREE_FORMAT;
    else status = mahd_pkg::ST_OK;
  end

  always_comb begin
    case (sidx)
      2'd0:    base_hz = 16'd44100;
      2'd1:    base_hz = 16'd48000;
      2'd2:    base_hz = 16'd32000;
      default: base_hz = 16'd0;
    endcase
    if (ver == mahd_pkg::VER_MPEG1) shift = 2'd0;
    else if (ver == mahd_pkg::VER_MPEG2) shift = 2'd1;
    else shift = 2'd2;
    sr_hz = base_hz >> shift;
    br    = mahd_pkg::bitrate_lookup(ver, lay, bidx);
  end

  // Slots times bitrate, scaled up by the sample rate divisor of MPEG2 and 2.5.
  always_comb begin
    case (lay)
      mahd_pkg::LAYER_1: kbr = 17'(br) * 17'd12;
      mahd_pkg::LAYER_2: kbr = 17'(br) * 17'd144;
      mahd_pkg::LAYER_3: kbr = (ver == mahd_pkg::VER_MPEG1) ? 17'(br) * 17'd144
                                                              : 17'(br) * 17'd72;
      default:           kbr = 17'd0;
    endcase
    slots_w = 19'(kbr) << shift;
  end

  always_comb begin
    item_nxt = '0;
    item_nxt.status = status;
    if (status != mahd_pkg::ST_NO_SYNC) begin
      item_nxt.version_code = ver;
      item_nxt.layer_code   = lay;
      item_nxt.crc_present  = ~in_tdata[16];
      item_nxt.padding_bit  = in_tdata[9];
      item_nxt.channel_mode = in_tdata[7:6];
    end
    if (status == mahd_pkg::ST_OK) item_nxt.bitrate_kbps = br;
    if (status == mahd_pkg::ST_OK || status == mahd_pkg::ST_FREE_FORMAT) begin
      item_nxt.sample_rate_hz = sr_hz;
    end
    item_nxt.slots     = slots_w[16:0];
    item_nxt.layer_one = (lay == mahd_pkg::LAYER_1);
    case (sidx)
      2'd0:    item_nxt.base_sel = mahd_pkg::BASE_44K1;
      2'd1:    item_nxt.base_sel = mahd_pkg::BASE_48K;
      default: item_nxt.base_sel = mahd_pkg::BASE_32K;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (q_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

// ===== sv/mahd_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front and back parts.
// Depends on mahd_pkg and the shared assertion macros.
`include "mpeg_audio_header_decoder_unit_defines.svh"
module mahd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mahd_pkg::item_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output mahd_pkg::item_t  out_item
);

  logic [1:0]      count_r, count_nxt;
  mahd_pkg::item_t head_r, head_nxt, tail_r, tail_nxt;
  logic            push, pop;

  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = head_r;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) head_nxt = in_item;
        else tail_nxt = in_item;
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        head_nxt  = tail_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = in_item;
        end else begin
          head_nxt = tail_r;
          tail_nxt = in_item;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  `MAHD_ASSERT_NOW(a_count_range, 1'b1, count_r != 2'd3, "queue count out of range")
  `MAHD_ASSERT_NEXT(a_drain_last, pop && !push && count_r == 2'd1, count_r == 2'd0,
                    "queue did not empty after last transfer out")
  `MAHD_ASSERT_NEXT(a_fill_empty, push && count_r == 2'd0, out_valid,
                    "queue not valid after transfer into empty queue")

endmodule

// ===== sv/mahd_back.sv =====
`timescale 1ns / 1ps
// Back part: frame length by reciprocal multiplication and the result register.
// Depends on mahd_pkg and the shared assertion macros.
`include "mpeg_audio_header_decoder_unit_defines.svh"
module mahd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  mahd_pkg::item_t    q_item,
  output logic               out_tvalid,
  input  logic               out_tready,
  output mahd_pkg::result_t  out_result
);

  logic              valid_r, valid_nxt;
  mahd_pkg::result_t res_r, res_nxt;
  logic [21:0]       recip;
  logic [38:0]       prod;
  logic [11:0]       quot, quot_pad;
  logic              take;

  assign take    = q_valid && q_ready;
  assign q_ready = !valid_r || out_tready;

  always_comb begin
    case (q_item.base_sel)
      mahd_pkg::BASE_44K1: recip = mahd_pkg::RECIP_44K1;
      mahd_pkg::BASE_48K:  recip = mahd_pkg::RECIP_48K;
      default:             recip = mahd_pkg::RECIP_32K;
    endcase
    prod     = 39'(q_item.slots) * 39'(recip);
    quot     = prod[mahd_pkg::RECIP_SHIFT +: 12];
    quot_pad = quot + 12'(q_item.padding_bit);
  end

  always_comb begin
    res_nxt.status         = q_item.status;
    res_nxt.version_code   = q_item.version_code;
    res_nxt.layer_code     = q_item.layer_code;
    res_nxt.crc_present    = q_item.crc_present;
    res_nxt.bitrate_kbps   = q_item.bitrate_kbps;
    res_nxt.sample_rate_hz = q_item.sample_rate_hz;
    res_nxt.padding_bit    = q_item.padding_bit;
    res_nxt.channel_mode   = q_item.channel_mode;
    if (q_item.status != mahd_pkg::ST_OK) res_nxt.frame_length = 12'd0;
    else if (q_item.layer_one) res_nxt.frame_length = {quot_pad[9:0], 2'b00};
    else res_nxt.frame_length = quot_pad;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_result = res_r;

  `MAHD_ASSERT_NOW(a_len_only_ok, valid_r && res_r.status != mahd_pkg::ST_OK,
                   res_r.frame_length == 12'd0, "frame length set on a faulty header")
  `MAHD_ASSERT_NOW(a_nosync_clear, valid_r && res_r.status == mahd_pkg::ST_NO_SYNC,
                   res_r.bitrate_kbps == 9'd0 && res_r.sample_rate_hz == 16'd0 &&
                   res_r.version_code == 2'd0, "fields set without sync")

endmodule

// ===== sv/mpeg_audio_header_decoder_unit.sv =====
`timescale 1ns / 1ps
// MPEG audio frame header decoder, top level.
// Joins mahd_front, mahd_fifo and mahd_back; uses mahd_pkg.
//
// The in_ channel carries one 32-bit candidate frame header per transfer,
// bit 31 being the first bit of the stream. For every header the out_
// channel returns exactly one result: status, raw version, layer, CRC,
// padding and channel mode bits, table bitrate and sample rate, and the
// frame length in bytes, in the order the headers arrived.
// A header is classified in the front register, waits in a two-entry
// queue and has its frame length formed in the back register, which
// divides by the sample rate through one 17 x 22 bit reciprocal multiply.
// A result passes through the front register, the queue and the back register
// before it appears on the out_ ports, and the block takes one
// header every cycle while the receiver keeps up.
// When out_tready is low the result holds, the queue fills and in_tready
// falls only once the queue and the front register are both full.
// A synchronous reset with rst_n low empties every stage; no table needs
// initialising, so headers are taken in the first cycle after reset.
module mpeg_audio_header_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // header_word[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], version_code[4:3], layer_code[6:5], crc_present[7],
  // bitrate_kbps[16:8], sample_rate_hz[32:17], padding_bit[33],
  // channel_mode[35:34], frame_length[47:36]
  output logic [47:0] out_tdata
);

  logic              fq_valid, fq_ready, qb_valid, qb_ready;
  mahd_pkg::item_t   fq_item, qb_item;
  mahd_pkg::result_t result;

  mahd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  mahd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  mahd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_item     (qb_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_result (result)
  );

  assign out_tdata = result;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mpeg_audio_header_decoder_unit; uses mahd_pkg.
// Directed and random frame headers go through the stream ports, and every result transfer
// is checked field by field against a decoder of the header tables written here.
module tb_top;
  import mahd_pkg::*;

  localparam int DIRECTED_COUNT = 24;
  localparam int RANDOM_COUNT   = 1530;
  localparam int TOTAL_HEADERS  = DIRECTED_COUNT + RANDOM_COUNT;
  localparam int PHASE_LEN      = TOTAL_HEADERS / 3;
  localparam int HOLD_CYCLES    = 60;
  localparam int HOLD_AT_A      = 200;
  localparam int HOLD_AT_B      = 2 * PHASE_LEN + 20;

  typedef struct {
    logic [31:0] word;
    bit          drain_first;
  } header_req_t;

  localparam int unsigned KBPS_V1_L1 [16] = '{0, 32, 64, 96, 128, 160, 192, 224,
    256, 288, 320, 352, 384, 416, 448, 0};
  localparam int unsigned KBPS_V1_L2 [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
    128, 160, 192, 224, 256, 320, 384, 0};
  localparam int unsigned KBPS_V1_L3 [16] = '{0, 32, 40, 48, 56, 64, 80, 96,
    112, 128, 160, 192, 224, 256, 320, 0};
  localparam int unsigned KBPS_V2_L1 [16] = '{0, 32, 48, 56, 64, 80, 96, 112,
    128, 144, 160, 176, 192, 224, 256, 0};
  localparam int unsigned KBPS_V2_L23 [16] = '{0, 8, 16, 24, 32, 40, 48, 56,
    64, 80, 96, 112, 128, 144, 160, 0};
  localparam int unsigned BASE_RATE_HZ [3] = '{44100, 48000, 32000};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  header_req_t pending_headers[$];
  result_t     expected_results[$];
  logic        in_taken = 1'b0;
  int          headers_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          status_count [8];
  int          hold_left = 0;
  int          holds_done = 0;

  mpeg_audio_header_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t decode_header(input logic [31:0] w);
    result_t     r;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    int unsigned kbps;
    int unsigned hz;
    int unsigned len;
    r = '0;
    ver  = w[20:19];
    lay  = w[18:17];
    bidx = w[15:12];
    sidx = w[11:10];
    if (w[31:21] != SYNC_PATTERN) begin
      r.status = ST_NO_SYNC;
      return r;
    end
    r.version_code = ver;
    r.layer_code   = lay;
    r.crc_present  = ~w[16];
    r.padding_bit  = w[9];
    r.channel_mode = w[7:6];
    if (ver == VER_RSV) r.status = ST_RSV_VERSION;
    else if (lay == LAYER_RSV) r.status = ST_RSV_LAYER;
    else if (bidx == BIDX_BAD) r.status = ST_BAD_BITRATE;
    else if (sidx == SIDX_RSV) r.status = ST_RSV_RATE;
    else if (bidx == BIDX_FREE) r.status = ST_FREE_FORMAT;
    else r.status = ST_OK;
    if (r.status != ST_OK && r.status != ST_FREE_FORMAT) return r;
    hz = BASE_RATE_HZ[sidx];
    if (ver == VER_MPEG2) hz = hz / 2;
    else if (ver == VER_MPEG25) hz = hz / 4;
    r.sample_rate_hz = hz[15:0];
    if (r.status == ST_FREE_FORMAT) return r;
    if (ver == VER_MPEG1) begin
      if (lay == LAYER_1) kbps = KBPS_V1_L1[bidx];
      else if (lay == LAYER_2) kbps = KBPS_V1_L2[bidx];
      else kbps = KBPS_V1_L3[bidx];
    end else begin
      if (lay == LAYER_1) kbps = KBPS_V2_L1[bidx];
      else kbps = KBPS_V2_L23[bidx];
    end
    if (lay == LAYER_1) len = ((12 * kbps * 1000) / hz + w[9]) * 4;
    else if (lay == LAYER_3 && ver != VER_MPEG1) len = (72 * kbps * 1000) / hz + w[9];
    else len = (144 * kbps * 1000) / hz + w[9];
    r.bitrate_kbps = kbps[8:0];
    r.frame_length = len[11:0];
    return r;
  endfunction

  // misc carries the protection bit, the private bit and the six lowest header bits.
  function automatic logic [31:0] make_header(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] bidx, input logic [1:0] sidx,
                                              input logic pad, input logic [1:0] chm,
                                              input logic [7:0] misc);
    return {SYNC_PATTERN, ver, lay, misc[7], bidx, sidx, pad, misc[6], chm, misc[5:0]};
  endfunction

  function automatic int sender_idle_pct();
    if (headers_sent < PHASE_LEN) return 17;
    if (headers_sent < 2 * PHASE_LEN) return 50;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (headers_sent < PHASE_LEN) return 50;
    if (headers_sent < 2 * PHASE_LEN) return 17;
    return 0;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    header_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_headers.size() == 0 ||
          (pending_headers[0].drain_first && expected_results.size() != 0) ||
          $urandom_range(0, 99) < sender_idle_pct()) begin
        in_tvalid <= 1'b0;
      end else begin
        req = pending_headers.pop_front();
        in_tdata  <= req.word;
        in_tvalid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if ((holds_done == 0 && headers_sent >= HOLD_AT_A) ||
                 (holds_done == 1 && headers_sent >= HOLD_AT_B)) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(decode_header(in_tdata));
        headers_sent++;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no header outstanding: %h", out_tdata);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          status_count[exp_r.status]++;
          check_field("status", exp_r.status, got.status);
          check_field("version_code", exp_r.version_code, got.version_code);
          check_field("layer_code", exp_r.layer_code, got.layer_code);
          check_field("crc_present", exp_r.crc_present, got.crc_present);
          check_field("bitrate_kbps", exp_r.bitrate_kbps, got.bitrate_kbps);
          check_field("sample_rate_hz", exp_r.sample_rate_hz, got.sample_rate_hz);
          check_field("padding_bit", exp_r.padding_bit, got.padding_bit);
          check_field("channel_mode", exp_r.channel_mode, got.channel_mode);
          check_field("frame_length", exp_r.frame_length, got.frame_length);
        end
      end
    end
  end

  initial begin
    header_req_t req;
    int          pick;
    logic [1:0]  ver_pool [3];
    ver_pool = '{VER_MPEG25, VER_MPEG2, VER_MPEG1};
    foreach (status_count[i]) status_count[i] = 0;
    req.drain_first = 1'b0;
    req.word = 32'h0000_0000; pending_headers.push_back(req);
    req.word = 32'hFFFF_FFFF; pending_headers.push_back(req);
    req.word = 32'hFFE0_0000; pending_headers.push_back(req);
    req.word = 32'hFFDF_FFFF; pending_headers.push_back(req);
    req.word = make_header(VER_RSV, LAYER_RSV, BIDX_BAD, SIDX_RSV, 1, 3, 8'hFF);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_RSV, BIDX_BAD, SIDX_RSV, 0, 2, 8'h00);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_2, BIDX_BAD, SIDX_RSV, 1, 1, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_3, BIDX_FREE, SIDX_RSV, 0, 0, 8'h55);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG2, LAYER_1, BIDX_FREE, 2'd1, 1, 3, 8'hAA);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG25, LAYER_3, BIDX_FREE, 2'd2, 0, 0, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_1, 4'd14, 2'd2, 1, 0, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_1, 4'd1, 2'd0, 0, 1, 8'h00);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_2, 4'd14, 2'd2, 1, 2, 8'hC0);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_3, 4'd9, 2'd0, 0, 1, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_3, 4'd14, 2'd1, 1, 3, 8'h3F);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG2, LAYER_1, 4'd14, 2'd0, 1, 0, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG2, LAYER_2, 4'd1, 2'd1, 0, 2, 8'h00);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG2, LAYER_3, 4'd14, 2'd2, 1, 1, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG25, LAYER_1, 4'd13, 2'd0, 0, 3, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG25, LAYER_2, 4'd14, 2'd2, 1, 0, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG25, LAYER_3, 4'd14, 2'd2, 1, 2, 8'h40);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG25, LAYER_3, 4'd1, 2'd0, 0, 1, 8'h80);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_2, 4'd8, 2'd1, 1, 3, 8'hFF);
    pending_headers.push_back(req);
    req.word = make_header(VER_MPEG1, LAYER_2, 4'd8, 2'd1, 0, 1, 8'h00);
    pending_headers.push_back(req);
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        req.word = make_header(ver_pool[$urandom_range(0, 2)], 2'($urandom_range(1, 3)),
                               4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
                               1'($urandom), 2'($urandom), 8'($urandom));
      else if (pick < 90)
        req.word = {SYNC_PATTERN, 21'($urandom)};
      else
        req.word = $urandom;
      // The first random header and the first of the unthrottled phase wait for a drained block.
      req.drain_first = (i == 0) || (DIRECTED_COUNT + i == 2 * PHASE_LEN);
      pending_headers.push_back(req);
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_headers.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d headers and %0d result transfers under three throttling phases.",
             headers_sent, results_seen);
    $display("Outcomes: %0d valid frames, %0d free format, %0d lost sync, %0d other faults.",
             status_count[ST_OK], status_count[ST_FREE_FORMAT], status_count[ST_NO_SYNC],
             results_seen - status_count[ST_OK] - status_count[ST_FREE_FORMAT]
             - status_count[ST_NO_SYNC]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mahd_pkg.sv
sv/mahd_front.sv
sv/mahd_fifo.sv
sv/mahd_back.sv
sv/mpeg_audio_header_decoder_unit.sv
verif/tb_top.sv
